// ===== rtl/lup_pkg.sv =====
// ----------------------------------------------------------------------------
// lup_pkg
// Shared types, result codes and character constants of the literal
// unescape parser.
// ----------------------------------------------------------------------------
package lup_pkg;

  localparam int LENGTH_BITS = 16;
  localparam int BUF_DEPTH   = 4;   // most results one item can cause
  localparam int BUF_IDX_W   = $clog2(BUF_DEPTH);
  localparam int BUF_CNT_W   = $clog2(BUF_DEPTH + 1);

  typedef logic [7:0]             byte_t;
  typedef logic [3:0]             rkind_t;
  typedef logic [LENGTH_BITS-1:0] len_t;

  // result kinds
  localparam rkind_t RK_BYTE      = 4'd0;
  localparam rkind_t RK_DONE      = 4'd1;
  localparam rkind_t RK_NOT_LIT   = 4'd2;
  localparam rkind_t RK_EOF       = 4'd3;
  localparam rkind_t RK_NEWLINE   = 4'd4;
  localparam rkind_t RK_HEX_EMPTY = 4'd5;
  localparam rkind_t RK_HEX_SHORT = 4'd6;
  localparam rkind_t RK_DANGLING  = 4'd7;
  localparam rkind_t RK_CHAR_LONG = 4'd8;
  localparam rkind_t RK_CHAR_EMPTY = 4'd9;
  localparam rkind_t RK_BAD_POINT = 4'd10;

  // literal kinds
  localparam logic LK_STRING = 1'b0;
  localparam logic LK_CHAR   = 1'b1;

  // characters
  localparam byte_t CH_DQUOTE = 8'h22;
  localparam byte_t CH_SQUOTE = 8'h27;
  localparam byte_t CH_BSLASH = 8'h5C;
  localparam byte_t CH_LF     = 8'h0A;
  localparam byte_t CH_CR     = 8'h0D;
  localparam byte_t CH_TAB    = 8'h09;
  localparam byte_t CH_VTAB   = 8'h0B;
  localparam byte_t CH_NUL    = 8'h00;
  localparam byte_t CH_ZERO   = 8'h30;
  localparam byte_t CH_LOW_N  = 8'h6E;
  localparam byte_t CH_LOW_R  = 8'h72;
  localparam byte_t CH_LOW_T  = 8'h74;
  localparam byte_t CH_LOW_V  = 8'h76;
  localparam byte_t CH_LOW_U  = 8'h75;
  localparam byte_t CH_UP_U   = 8'h55;

  localparam logic [3:0] HEX_DIGITS_SHORT = 4'd4;
  localparam logic [3:0] HEX_DIGITS_WIDE  = 4'd8;

  localparam logic [31:0] CP_MAX       = 32'h0010_FFFF;
  localparam logic [31:0] CP_SURR_LO   = 32'h0000_D800;
  localparam logic [31:0] CP_SURR_HI   = 32'h0000_DFFF;

  // {valid, value}
  function automatic logic [4:0] hex_digit(input byte_t b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39)      r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    return r;
  endfunction

endpackage

// ===== rtl/lup_in_if.sv =====
// ----------------------------------------------------------------------------
// lup_in_if
// Source byte channel: valid/ready plus one raw byte and end mark.
// ----------------------------------------------------------------------------
interface lup_in_if import lup_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t source_byte;
  logic  at_end;

  modport source (output valid, output source_byte, output at_end, input ready);
  modport sink   (input valid, input source_byte, input at_end, output ready);
endinterface

// ===== rtl/lup_out_if.sv =====
// ----------------------------------------------------------------------------
// lup_out_if
// Result channel: valid/ready plus one decoded result.
// ----------------------------------------------------------------------------
interface lup_out_if import lup_pkg::*; ();
  logic   valid;
  logic   ready;
  rkind_t result_kind;
  byte_t  data_byte;
  len_t   raw_length;
  logic   last;

  modport source (output valid, output result_kind, output data_byte,
                  output raw_length, output last, input ready);
  modport sink   (input valid, input result_kind, input data_byte,
                  input raw_length, input last, output ready);
endinterface

// ===== rtl/lup_cfg_if.sv =====
// ----------------------------------------------------------------------------
// lup_cfg_if
// Configuration write channel for the literal kind register.
// ----------------------------------------------------------------------------
interface lup_cfg_if import lup_pkg::*; ();
  logic valid;
  logic ready;
  logic literal_kind;

  modport source (output valid, output literal_kind, input ready);
  modport sink   (input valid, input literal_kind, output ready);
endinterface

// ===== rtl/literal_unescape_parser.sv =====
// Latency: first result of a beat is presented the cycle after the input beat.
// Throughput: one input beat per cycle while each beat causes at most one
//   result and out_ch is ready; a beat with N results holds the result buffer
//   until all N are taken (N up to 4, set by UTF-8 expansion of a \u or \U escape).
// Reset: synchronous, active low; parser returns to idle, result buffer empties,
//   literal kind becomes string.
// ----------------------------------------------------------------------------
// literal_unescape_parser
// Decodes one quoted string or char literal, one source byte per beat, with
// escape and UTF-8 handling; results drain from a small result buffer.
// ----------------------------------------------------------------------------
module literal_unescape_parser import lup_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  lup_in_if.sink   in_ch,
  lup_out_if.source out_ch,
  lup_cfg_if.sink  cfg_ch
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_BODY = 2'd1;
  localparam logic [1:0] PH_ESC  = 2'd2;
  localparam logic [1:0] PH_HEX  = 2'd3;

  logic        kind_r;
  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] hex_value_r, hex_value_nxt;
  logic [3:0]  hex_count_r, hex_count_nxt;
  logic        wide_r, wide_nxt;
  logic [1:0]  cbc_r, cbc_nxt;
  byte_t       char_value_r, char_value_nxt;
  len_t        consumed_r, consumed_nxt;

  rkind_t               buf_kind_r [BUF_DEPTH];
  byte_t                buf_byte_r [BUF_DEPTH];
  len_t                 buf_len_r;
  logic [BUF_CNT_W-1:0] buf_cnt_r;
  logic [BUF_IDX_W-1:0] buf_idx_r;

  // comb decode results
  byte_t                pb [BUF_DEPTH];
  logic [BUF_CNT_W-1:0] pn;
  logic                 term_vld;
  rkind_t               term_kind;
  byte_t                term_byte;
  len_t                 cons_step;
  logic [4:0]           hd;
  logic [31:0]          cp;
  logic [3:0]           hc_inc;
  logic [3:0]           hex_need;
  byte_t                b;
  byte_t                delim;
  rkind_t               res_kind [BUF_DEPTH];
  byte_t                res_byte [BUF_DEPTH];
  logic [BUF_CNT_W-1:0] res_n;

  logic in_fire, out_fire, out_last;

  assign b        = in_ch.source_byte;
  assign delim    = (kind_r == LK_CHAR) ? CH_SQUOTE : CH_DQUOTE;
  assign out_last = ({1'b0, buf_idx_r} + BUF_CNT_W'(1)) == buf_cnt_r;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (buf_cnt_r == '0) || (out_fire && out_last);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid       = buf_cnt_r != '0;
  assign out_ch.result_kind = buf_kind_r[buf_idx_r];
  assign out_ch.data_byte   = buf_byte_r[buf_idx_r];
  assign out_ch.raw_length  = (buf_kind_r[buf_idx_r] == RK_DONE) ? buf_len_r : '0;
  assign out_ch.last        = out_last;

  always_comb begin
    phase_nxt      = phase_r;
    hex_value_nxt  = hex_value_r;
    hex_count_nxt  = hex_count_r;
    wide_nxt       = wide_r;
    cbc_nxt        = cbc_r;
    char_value_nxt = char_value_r;
    pn        = '0;
    term_vld  = 1'b0;
    term_kind = RK_BYTE;
    term_byte = CH_NUL;
    for (int i = 0; i < BUF_DEPTH; i++) pb[i] = CH_NUL;

    cons_step = (phase_r != PH_IDLE && !in_ch.at_end && consumed_r != '1)
              ? consumed_r + len_t'(1) : consumed_r;
    consumed_nxt = cons_step;

    hd       = hex_digit(b);
    cp       = {hex_value_r[27:0], hd[3:0]};
    hc_inc   = hex_count_r + 4'd1;
    hex_need = wide_r ? HEX_DIGITS_WIDE : HEX_DIGITS_SHORT;

    unique case (phase_r)
      PH_IDLE: begin
        if (in_ch.at_end || b != delim) begin
          term_vld  = 1'b1;
          term_kind = RK_NOT_LIT;
        end else begin
          consumed_nxt   = len_t'(1);
          cbc_nxt        = 2'd0;
          char_value_nxt = CH_NUL;
          hex_value_nxt  = '0;
          hex_count_nxt  = '0;
          wide_nxt       = 1'b0;
          phase_nxt      = PH_BODY;
          if (kind_r == LK_STRING) begin
            term_vld  = 1'b1;
            term_kind = RK_BYTE;
            term_byte = CH_DQUOTE;
          end
        end
      end
      PH_BODY: begin
        if (in_ch.at_end) begin
          term_vld  = 1'b1;
          term_kind = RK_EOF;
        end else if (b == CH_LF) begin
          term_vld  = 1'b1;
          term_kind = RK_NEWLINE;
        end else if (b == CH_BSLASH) begin
          phase_nxt = PH_ESC;
        end else if (b == delim) begin
          term_vld = 1'b1;
          if (kind_r == LK_STRING) begin
            term_kind = RK_DONE;
            term_byte = CH_DQUOTE;
          end else if (cbc_r == 2'd0) begin
            term_kind = RK_CHAR_EMPTY;
          end else if (cbc_r > 2'd1) begin
            term_kind = RK_CHAR_LONG;
          end else begin
            term_kind = RK_DONE;
            term_byte = char_value_r;
          end
          // done and both char errors all go idle
          phase_nxt = PH_IDLE;
        end else begin
          pn    = BUF_CNT_W'(1);
          pb[0] = b;
        end
      end
      PH_ESC: begin
        if (in_ch.at_end) begin
          term_vld  = 1'b1;
          term_kind = RK_DANGLING;
        end else begin
          phase_nxt = PH_BODY;
          pn        = BUF_CNT_W'(1);
          unique case (b)
            CH_BSLASH: pb[0] = CH_BSLASH;
            CH_ZERO:   pb[0] = CH_NUL;
            CH_SQUOTE: pb[0] = CH_SQUOTE;
            CH_DQUOTE: pb[0] = CH_DQUOTE;
            CH_LOW_N:  pb[0] = CH_LF;
            CH_LOW_R:  pb[0] = CH_CR;
            CH_LOW_T:  pb[0] = CH_TAB;
            CH_LOW_V:  pb[0] = CH_VTAB;
            CH_LOW_U, CH_UP_U: begin
              pn            = '0;
              hex_value_nxt = '0;
              hex_count_nxt = '0;
              wide_nxt      = (b == CH_UP_U);
              phase_nxt     = PH_HEX;
            end
            default: begin
              // unknown escape: backslash passes, then the byte as body text
              // (both quotes and backslash are escapes, so no close here)
              pb[0] = CH_BSLASH;
              if (b == CH_LF) begin
                term_vld  = 1'b1;
                term_kind = RK_NEWLINE;
              end else begin
                pn    = BUF_CNT_W'(2);
                pb[1] = b;
              end
            end
          endcase
        end
      end
      PH_HEX: begin
        if (in_ch.at_end || !hd[4]) begin
          term_vld  = 1'b1;
          term_kind = (hex_count_r == '0) ? RK_HEX_EMPTY : RK_HEX_SHORT;
        end else begin
          hex_value_nxt = cp;
          hex_count_nxt = hc_inc;
          if (hc_inc >= hex_need) begin
            phase_nxt = PH_BODY;
            if (cp == '0) begin
              pn = '0;
            end else if (cp > CP_MAX || (cp >= CP_SURR_LO && cp <= CP_SURR_HI)) begin
              term_vld  = 1'b1;
              term_kind = RK_BAD_POINT;
            end else if (cp < 32'h80) begin
              pn    = BUF_CNT_W'(1);
              pb[0] = cp[7:0];
            end else if (cp < 32'h800) begin
              pn    = BUF_CNT_W'(2);
              pb[0] = {3'b110, cp[10:6]};
              pb[1] = {2'b10, cp[5:0]};
            end else if (cp < 32'h1_0000) begin
              pn    = BUF_CNT_W'(3);
              pb[0] = {4'b1110, cp[15:12]};
              pb[1] = {2'b10, cp[11:6]};
              pb[2] = {2'b10, cp[5:0]};
            end else begin
              pn    = BUF_CNT_W'(4);
              pb[0] = {5'b11110, cp[20:18]};
              pb[1] = {2'b10, cp[17:12]};
              pb[2] = {2'b10, cp[11:6]};
              pb[3] = {2'b10, cp[5:0]};
            end
          end
        end
      end
    endcase

    // any error result returns to idle
    if (term_vld && term_kind != RK_BYTE && term_kind != RK_DONE) phase_nxt = PH_IDLE;

    // char mode: bytes only count, first one kept
    if (kind_r == LK_CHAR) begin
      for (int i = 0; i < BUF_DEPTH; i++) begin
        if (BUF_CNT_W'(i) < pn) begin
          if (cbc_nxt == 2'd0) char_value_nxt = pb[i];
          if (cbc_nxt < 2'd2)  cbc_nxt = cbc_nxt + 2'd1;
        end
      end
    end

    // assemble result list: bytes first, terminal result after
    for (int i = 0; i < BUF_DEPTH; i++) begin
      res_kind[i] = RK_BYTE;
      res_byte[i] = pb[i];
    end
    res_n = (kind_r == LK_STRING) ? pn : '0;
    if (term_vld) begin
      res_kind[res_n[BUF_IDX_W-1:0]] = term_kind;
      res_byte[res_n[BUF_IDX_W-1:0]] = term_byte;
      res_n = res_n + BUF_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r       <= LK_STRING;
      phase_r      <= PH_IDLE;
      hex_value_r  <= '0;
      hex_count_r  <= '0;
      wide_r       <= 1'b0;
      cbc_r        <= '0;
      char_value_r <= CH_NUL;
      consumed_r   <= '0;
      buf_cnt_r    <= '0;
      buf_idx_r    <= '0;
    end else begin
      if (cfg_ch.valid) kind_r <= cfg_ch.literal_kind;
      if (in_fire) begin
        phase_r      <= phase_nxt;
        hex_value_r  <= hex_value_nxt;
        hex_count_r  <= hex_count_nxt;
        wide_r       <= wide_nxt;
        cbc_r        <= cbc_nxt;
        char_value_r <= char_value_nxt;
        consumed_r   <= consumed_nxt;
        buf_cnt_r    <= res_n;
        buf_idx_r    <= '0;
      end else if (out_fire) begin
        if (out_last) begin
          buf_cnt_r <= '0;
          buf_idx_r <= '0;
        end else begin
          buf_idx_r <= buf_idx_r + BUF_IDX_W'(1);
        end
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < BUF_DEPTH; i++) begin
        buf_kind_r[i] <= res_kind[i];
        buf_byte_r[i] <= res_byte[i];
      end
      buf_len_r <= cons_step;
    end
  end

endmodule

// ===== rtl/lup_chk.sv =====
// ----------------------------------------------------------------------------
// lup_chk
// Port-level checks of the literal unescape parser, bound to the top level.
// ----------------------------------------------------------------------------
module lup_chk import lup_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input rkind_t out_kind,
  input byte_t  out_byte,
  input len_t   out_length,
  input logic   out_last
);

  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_kind) && $stable(out_byte)
                                && $stable(out_length) && $stable(out_last))
    else $error("result payload changed while stalled");

  a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("result burst ended without last");

  a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  a_length_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != RK_DONE |-> out_length == '0)
    else $error("raw length set on a result other than done");

endmodule

bind literal_unescape_parser lup_chk u_lup_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_kind   (out_ch.result_kind),
  .out_byte   (out_ch.data_byte),
  .out_length (out_ch.raw_length),
  .out_last   (out_ch.last)
);

// ===== tb/sv/tb_literal_unescape_parser.sv =====
// ----------------------------------------------------------------------------
// tb_literal_unescape_parser
// Self-checking bench for the literal unescape parser. Source bytes are fed
// as quoted literals with random content (escapes, \u and \U code points,
// raw bytes, broken endings) in both literal kinds. A scoreboard predicts
// every result beat and checks each one as it leaves the block.
// ----------------------------------------------------------------------------
module tb_literal_unescape_parser;
  import lup_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BEATS = 400;

  typedef enum logic [1:0] {ST_IDLE, ST_BODY, ST_ESC, ST_HEX} parse_state_t;

  typedef struct packed {
    rkind_t kind;
    byte_t  data;
    len_t   length;
    logic   last;
  } result_t;

  typedef struct packed {
    byte_t data;
    logic  at_end;
  } src_beat_t;

  class literal_scoreboard;
    logic         lit_kind;
    parse_state_t state;
    logic [31:0]  hex_acc;
    logic [3:0]   hex_seen;
    logic         wide;
    logic [1:0]   char_count;
    byte_t        char_byte;
    len_t         consumed;
    result_t      expected_q[$];
    result_t      step_q[$];
    int           errors;

    function new();
      lit_kind   = LK_STRING;
      state      = ST_IDLE;
      hex_acc    = '0;
      hex_seen   = '0;
      wide       = 1'b0;
      char_count = '0;
      char_byte  = '0;
      consumed   = '0;
      errors     = 0;
    endfunction

    function void set_kind(logic k);
      lit_kind = k;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function byte_t delim();
      return (lit_kind == LK_CHAR) ? CH_SQUOTE : CH_DQUOTE;
    endfunction

    function void emit(rkind_t k, byte_t d, len_t l);
      result_t r;
      r.kind   = k;
      r.data   = d;
      r.length = l;
      r.last   = 1'b0;
      step_q.push_back(r);
    endfunction

    function void fail(rkind_t k);
      emit(k, '0, '0);
      state = ST_IDLE;
    endfunction

    // char literals only count decoded bytes and keep the first one
    function void put_byte(byte_t b);
      if (lit_kind == LK_STRING) begin
        emit(RK_BYTE, b, '0);
      end else begin
        if (char_count == 0) char_byte = b;
        if (char_count < 2) char_count++;
      end
    endfunction

    function void close_literal();
      if (lit_kind == LK_STRING) begin
        emit(RK_DONE, CH_DQUOTE, consumed);
        state = ST_IDLE;
      end else if (char_count == 0) begin
        fail(RK_CHAR_EMPTY);
      end else if (char_count > 1) begin
        fail(RK_CHAR_LONG);
      end else begin
        emit(RK_DONE, char_byte, consumed);
        state = ST_IDLE;
      end
    endfunction

    function void body_byte(byte_t b);
      if (b == CH_LF) fail(RK_NEWLINE);
      else if (b == CH_BSLASH) state = ST_ESC;
      else if (b == delim()) close_literal();
      else put_byte(b);
    endfunction

    function void encode_point(logic [31:0] cp);
      if (cp == 0) return;
      if (cp > CP_MAX || (cp >= CP_SURR_LO && cp <= CP_SURR_HI)) begin
        fail(RK_BAD_POINT);
      end else if (cp < 32'h80) begin
        put_byte(cp[7:0]);
      end else if (cp < 32'h800) begin
        put_byte({3'b110, cp[10:6]});
        put_byte({2'b10, cp[5:0]});
      end else if (cp < 32'h1_0000) begin
        put_byte({4'b1110, cp[15:12]});
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
      end else begin
        put_byte({5'b11110, cp[20:18]});
        put_byte({2'b10, cp[17:12]});
        put_byte({2'b10, cp[11:6]});
        put_byte({2'b10, cp[5:0]});
      end
    endfunction

    function int digit_value(byte_t b);
      if (b >= "0" && b <= "9") return int'(b) - int'(CH_ZERO);
      if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
      if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
      return -1;
    endfunction

    function void escape_byte(byte_t b);
      state = ST_BODY;
      case (b)
        CH_BSLASH: put_byte(CH_BSLASH);
        CH_ZERO:   put_byte(CH_NUL);
        CH_SQUOTE: put_byte(CH_SQUOTE);
        CH_DQUOTE: put_byte(CH_DQUOTE);
        CH_LOW_N:  put_byte(CH_LF);
        CH_LOW_R:  put_byte(CH_CR);
        CH_LOW_T:  put_byte(CH_TAB);
        CH_LOW_V:  put_byte(CH_VTAB);
        CH_LOW_U, CH_UP_U: begin
          hex_acc  = '0;
          hex_seen = '0;
          wide     = (b == CH_UP_U);
          state    = ST_HEX;
        end
        default: begin
          // unknown escape: backslash goes out, next byte is an ordinary one
          put_byte(CH_BSLASH);
          body_byte(b);
        end
      endcase
    endfunction

    function void note_source(byte_t b, logic at_end);
      int d;
      step_q.delete();
      if (state != ST_IDLE && !at_end && consumed != '1) consumed++;
      case (state)
        ST_IDLE: begin
          if (at_end || b != delim()) begin
            emit(RK_NOT_LIT, '0, '0);
          end else begin
            consumed   = len_t'(1);
            char_count = '0;
            char_byte  = '0;
            hex_acc    = '0;
            hex_seen   = '0;
            wide       = 1'b0;
            if (lit_kind == LK_STRING) emit(RK_BYTE, CH_DQUOTE, '0);
            state = ST_BODY;
          end
        end
        ST_BODY: begin
          if (at_end) fail(RK_EOF);
          else body_byte(b);
        end
        ST_ESC: begin
          if (at_end) fail(RK_DANGLING);
          else escape_byte(b);
        end
        default: begin
          d = at_end ? -1 : digit_value(b);
          if (d < 0) begin
            fail(hex_seen == 0 ? RK_HEX_EMPTY : RK_HEX_SHORT);
          end else begin
            hex_acc = {hex_acc[27:0], 4'(d)};
            hex_seen++;
            if (hex_seen >= (wide ? HEX_DIGITS_WIDE : HEX_DIGITS_SHORT)) begin
              state = ST_BODY;
              encode_point(hex_acc);
            end
          end
        end
      endcase
      if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 200) $display("ERROR at %0t: %s", $time, msg);
    endtask

    task check_result(rkind_t k, byte_t d, len_t l, logic lst);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing pending: kind %0d data %02h", k, d));
        return;
      end
      want = expected_q.pop_front();
      if (k != want.kind)
        report($sformatf("result_kind %0d, predicted %0d", k, want.kind));
      if (d != want.data)
        report($sformatf("data_byte %02h, predicted %02h (kind %0d)", d, want.data, want.kind));
      if (l != want.length)
        report($sformatf("raw_length %0d, predicted %0d", l, want.length));
      if (lst != want.last)
        report($sformatf("last %0b, predicted %0b (kind %0d)", lst, want.last, want.kind));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic calm;
  int   beats_sent;

  lup_in_if  in_ch();
  lup_out_if out_ch();
  lup_cfg_if cfg_ch();

  literal_scoreboard sb = new();
  src_beat_t         plan_q[$];

  literal_unescape_parser DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin : watchdog
    #2ms;
    $display("literal_unescape_parser: mismatch");
    $finish;
  end

  // result side: random stall bursts, none once the run winds down
  initial begin : result_sink
    out_ch.ready <= 1'b0;
    forever begin
      if (!calm && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.result_kind, out_ch.data_byte, out_ch.raw_length, out_ch.last);
  end

  function automatic void plan_byte(byte_t b);
    src_beat_t it;
    it.data   = b;
    it.at_end = 1'b0;
    plan_q.push_back(it);
  endfunction

  function automatic void plan_end();
    src_beat_t it;
    it.data   = byte_t'($urandom);
    it.at_end = 1'b1;
    plan_q.push_back(it);
  endfunction

  function automatic void plan_text(string s);
    for (int i = 0; i < s.len(); i++) plan_byte(byte_t'(s[i]));
  endfunction

  // n hex digits of value, most significant first, letters in random case
  function automatic void plan_hex(logic [31:0] value, int n);
    logic [3:0] nib;
    logic       upper;
    for (int i = n - 1; i >= 0; i--) begin
      nib   = value[4*i +: 4];
      upper = 1'($urandom_range(0, 1));
      if (nib < 10) plan_byte(byte_t'(CH_ZERO + nib));
      else plan_byte(byte_t'((upper ? "A" : "a") + nib - 10));
    end
  endfunction

  function automatic logic [31:0] pick_point(logic wide);
    case ($urandom_range(0, wide ? 7 : 5))
      0:       return 32'h0;
      1:       return $urandom_range(1, 32'h7F);
      2:       return $urandom_range(32'h80, 32'h7FF);
      3:       return $urandom_range(32'h800, 32'hD7FF);
      4:       return $urandom_range(32'hD800, 32'hDFFF);
      5:       return $urandom_range(32'hE000, 32'hFFFF);
      6:       return $urandom_range(32'h1_0000, 32'h10_FFFF);
      default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF
                                           : $urandom_range(32'h11_0000, 32'hFFFF_FFFF);
    endcase
  endfunction

  function automatic void plan_element(byte_t delim);
    int          r;
    byte_t       b;
    logic        wide;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      do b = byte_t'($urandom_range(32, 126)); while (b == delim || b == CH_BSLASH);
      plan_byte(b);
    end else if (r < 45) begin
      do b = byte_t'($urandom); while (b == delim || b == CH_BSLASH || b == CH_LF);
      plan_byte(b);
    end else if (r < 65) begin
      plan_byte(CH_BSLASH);
      case ($urandom_range(0, 7))
        0:       plan_byte(CH_BSLASH);
        1:       plan_byte(CH_ZERO);
        2:       plan_byte(CH_SQUOTE);
        3:       plan_byte(CH_DQUOTE);
        4:       plan_byte(CH_LOW_N);
        5:       plan_byte(CH_LOW_R);
        6:       plan_byte(CH_LOW_T);
        default: plan_byte(CH_LOW_V);
      endcase
    end else if (r < 72) begin
      plan_byte(CH_BSLASH);
      do b = byte_t'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(32, 126));
      while (b inside {CH_BSLASH, CH_ZERO, CH_SQUOTE, CH_DQUOTE, CH_LOW_N, CH_LOW_R,
                       CH_LOW_T, CH_LOW_V, CH_LOW_U, CH_UP_U, CH_LF});
      plan_byte(b);
    end else if (r < 97) begin
      wide = (r >= 85);
      plan_byte(CH_BSLASH);
      plan_byte(wide ? CH_UP_U : CH_LOW_U);
      plan_hex(pick_point(wide), wide ? 8 : 4);
    end else begin
      // hex escape cut short; the stray byte is eaten by the error
      wide = 1'($urandom_range(0, 1));
      plan_byte(CH_BSLASH);
      plan_byte(wide ? CH_UP_U : CH_LOW_U);
      plan_hex($urandom, $urandom_range(0, wide ? 7 : 3));
      if ($urandom_range(0, 3) == 0) begin
        plan_end();
      end else begin
        do b = byte_t'($urandom); while (b inside {["0":"9"], ["A":"F"], ["a":"f"]});
        plan_byte(b);
      end
    end
  endfunction

  function automatic void plan_literal(logic kind);
    byte_t delim;
    int    elems;
    int    r;
    delim = (kind == LK_CHAR) ? CH_SQUOTE : CH_DQUOTE;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      plan_byte(byte_t'($urandom));
      return;
    end
    if (r < 6) begin
      plan_end();
      return;
    end
    plan_byte(delim);
    if (kind == LK_CHAR) elems = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 3) : 1;
    else elems = $urandom_range(0, 8);
    repeat (elems) plan_element(delim);
    case ($urandom_range(0, 19))
      0: plan_end();
      1: plan_byte(CH_LF);
      2: begin
        plan_byte(CH_BSLASH);
        plan_end();
      end
      default: plan_byte(delim);
    endcase
  endfunction

  task automatic send_beat(byte_t b, logic e);
    if (!calm && $urandom_range(0, 11) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.source_byte <= b;
    in_ch.at_end      <= e;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_source(b, e);
    beats_sent++;
  endtask

  task automatic run_plan();
    src_beat_t it;
    while (plan_q.size() != 0) begin
      it = plan_q.pop_front();
      send_beat(it.data, it.at_end);
    end
  endtask

  // hold the sender until every predicted beat is out
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_kind(logic k);
    settle();
    cfg_ch.valid        <= 1'b1;
    cfg_ch.literal_kind <= k;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_kind(k);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    int   target;
    logic cur_kind;
    calm                <= 1'b0;
    beats_sent           = 0;
    in_ch.valid         <= 1'b0;
    in_ch.source_byte   <= '0;
    in_ch.at_end        <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.literal_kind <= LK_STRING;
    rst_n               <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // string mode: stray bytes at idle, escaped quote, zero code point,
    // unknown escape followed by raw newline, surrogate, short \U, eof
    plan_byte(8'hFF);
    plan_end();
    plan_text("\"\\\"\\u0000\\");
    plan_byte(CH_LF);
    plan_text("\"\\ud800");
    plan_text("\"\\U1");
    plan_end();
    plan_text("\"");
    plan_byte(CH_NUL);
    plan_end();
    run_plan();

    // char mode: empty, too long, hex with no digits, dangling backslash
    write_kind(LK_CHAR);
    plan_text("''");
    plan_text("'ab'");
    plan_text("'\\ug");
    plan_text("'\\");
    plan_end();
    run_plan();

    target = beats_sent + RANDOM_BEATS;
    cur_kind = LK_STRING;
    write_kind(cur_kind);
    while (beats_sent < target) begin
      if (target - beats_sent < 60) calm <= 1'b1;
      repeat ($urandom_range(4, 12)) plan_literal(cur_kind);
      run_plan();
      if (beats_sent < target) begin
        cur_kind = 1'($urandom_range(0, 1));
        write_kind(cur_kind);
      end
    end

    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("literal_unescape_parser: match");
    end else begin
      $display("literal_unescape_parser: mismatch");
    end
    $finish;
  end

endmodule
